// ===== src/kcl_pkg.sv =====
package kcl_pkg;

    // Number of BCD digits in a code. The field widths on the ports are fixed
    // at four digits, so this is a package constant and not a parameter.
    localparam int CODE_DIGITS = 4;
    localparam int CODE_W      = 4 * CODE_DIGITS;
    localparam int COUNT_W     = 3;
    localparam int TICKS_W     = 16;

    localparam logic [TICKS_W-1:0] AUTO_CLEAR_RESET = TICKS_W'(10000);
    localparam logic [CODE_W-1:0]  USER_CODE_RESET  = CODE_W'(16'h1234);
    localparam logic [CODE_W-1:0]  ADMIN_CODE_RESET = '0;
    localparam logic [COUNT_W-1:0] FULL_COUNT       = COUNT_W'(CODE_DIGITS);

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_KEY  = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    localparam logic [3:0] KEY_DIGIT_MIN = 4'd0;
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_ADMIN     = 4'd10;
    localparam logic [3:0] KEY_CLEAR     = 4'd12;
    localparam logic [3:0] KEY_DELETE    = 4'd13;
    localparam logic [3:0] KEY_STAR      = 4'd14;
    localparam logic [3:0] KEY_ENTER     = 4'd15;

    localparam logic        SEL_USER  = 1'b0;
    localparam logic        SEL_ADMIN = 1'b1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [3:0]        key;
        logic              code_select;
        logic [CODE_W-1:0] code_value;
    } kcl_in_t;

    typedef struct packed {
        logic               success_lamp;
        logic               fail_lamp;
        logic               admin_lamp;
        logic [COUNT_W-1:0] entry_count;
        logic [CODE_W-1:0]  entry_digits;
        logic               save_valid;
        logic               save_select;
        logic [CODE_W-1:0]  save_value;
    } kcl_out_t;

    // Clamps every BCD nibble above nine down to nine.
    function automatic logic [CODE_W-1:0] clamp_code(input logic [CODE_W-1:0] v);
        logic [CODE_W-1:0] r;
        r = '0;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            if (v[4*i +: 4] > KEY_DIGIT_MAX) begin
                r[4*i +: 4] = KEY_DIGIT_MAX;
            end else begin
                r[4*i +: 4] = v[4*i +: 4];
            end
        end
        return r;
    endfunction

endpackage

// ===== src/kcl_in_stage.sv =====
module kcl_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  kcl_pkg::kcl_in_t s_data,
    input  logic            advance,
    output logic            in_vld,
    output kcl_pkg::kcl_in_t in_data
);
    import kcl_pkg::*;

    logic    vld_reg;
    kcl_in_t data_reg;

    // The register may refill in the same cycle that its word moves on.
    assign s_ready = !vld_reg || advance;
    assign in_vld  = vld_reg;
    assign in_data = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

// ===== src/kcl_state.sv =====
module kcl_state (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  kcl_pkg::kcl_in_t              in_data,
    input  logic [kcl_pkg::TICKS_W-1:0]   auto_clear_ticks,
    output kcl_pkg::kcl_out_t             result
);
    import kcl_pkg::*;

    logic [CODE_W-1:0]  entry_reg,     entry_next;
    logic [COUNT_W-1:0] length_reg,    length_next;
    logic [CODE_W-1:0]  user_reg,      user_next;
    logic [CODE_W-1:0]  admin_code_reg, admin_code_next;
    logic               admin_reg,     admin_next;
    logic               success_reg,   success_next;
    logic               fail_reg,      fail_next;
    logic [TICKS_W-1:0] countdown_reg, countdown_next;

    logic               full;
    logic [COUNT_W-1:0] len_dec;
    logic [TICKS_W-1:0] arm_value;
    logic               save;
    logic               save_sel;
    logic [CODE_W-1:0]  save_val;

    assign full      = (length_reg == FULL_COUNT);
    assign len_dec   = length_reg - COUNT_W'(1);
    assign arm_value = (auto_clear_ticks == '0) ? TICKS_W'(1) : auto_clear_ticks;

    always_comb begin
        entry_next      = entry_reg;
        length_next     = length_reg;
        user_next       = user_reg;
        admin_code_next = admin_code_reg;
        admin_next      = admin_reg;
        success_next    = success_reg;
        fail_next       = fail_reg;
        countdown_next  = countdown_reg;
        save            = 1'b0;
        save_sel        = SEL_USER;
        save_val        = '0;

        case (in_data.opcode)
            OP_TICK: begin
                if (countdown_reg != '0) begin
                    countdown_next = countdown_reg - TICKS_W'(1);
                    if (countdown_reg == TICKS_W'(1)) begin
                        success_next = 1'b0;
                        fail_next    = 1'b0;
                    end
                end
            end
            OP_LOAD: begin
                if (in_data.code_select == SEL_ADMIN) begin
                    admin_code_next = clamp_code(in_data.code_value);
                end else begin
                    user_next = clamp_code(in_data.code_value);
                end
            end
            OP_KEY: begin
                success_next   = 1'b0;
                fail_next      = 1'b0;
                countdown_next = '0;
                if (in_data.key inside {[KEY_DIGIT_MIN:KEY_DIGIT_MAX]}) begin
                    if (!full) begin
                        for (int i = 0; i < CODE_DIGITS; i++) begin
                            if (length_reg == COUNT_W'(i)) begin
                                entry_next[4*(CODE_DIGITS-1-i) +: 4] = in_data.key;
                            end
                        end
                        length_next = length_reg + COUNT_W'(1);
                    end
                end else begin
                    case (in_data.key)
                        KEY_DELETE: begin
                            if (length_reg != '0) begin
                                length_next = len_dec;
                                for (int i = 0; i < CODE_DIGITS; i++) begin
                                    if (len_dec == COUNT_W'(i)) begin
                                        entry_next[4*(CODE_DIGITS-1-i) +: 4] = 4'd0;
                                    end
                                end
                            end
                        end
                        KEY_CLEAR: begin
                            entry_next  = '0;
                            length_next = '0;
                        end
                        KEY_ENTER: begin
                            countdown_next = arm_value;
                            if (admin_reg) begin
                                if (!full) begin
                                    fail_next = 1'b1;
                                end else begin
                                    user_next    = entry_reg;
                                    save         = 1'b1;
                                    save_sel     = SEL_USER;
                                    save_val     = entry_reg;
                                    success_next = 1'b1;
                                    entry_next   = '0;
                                    length_next  = '0;
                                end
                            end else begin
                                success_next = full && (entry_reg == user_reg);
                                fail_next    = !(full && (entry_reg == user_reg));
                                entry_next   = '0;
                                length_next  = '0;
                            end
                        end
                        KEY_ADMIN: begin
                            if (admin_reg) begin
                                admin_next = 1'b0;
                            end else begin
                                if (full && (entry_reg == admin_code_reg)) begin
                                    admin_next = 1'b1;
                                end else begin
                                    fail_next      = 1'b1;
                                    countdown_next = arm_value;
                                end
                                entry_next  = '0;
                                length_next = '0;
                            end
                        end
                        KEY_STAR: begin
                            if (admin_reg) begin
                                countdown_next = arm_value;
                                if (!full) begin
                                    fail_next = 1'b1;
                                end else begin
                                    admin_code_next = entry_reg;
                                    save            = 1'b1;
                                    save_sel        = SEL_ADMIN;
                                    save_val        = entry_reg;
                                    success_next    = 1'b1;
                                    entry_next      = '0;
                                    length_next     = '0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.success_lamp = success_next;
        result.fail_lamp    = fail_next;
        result.admin_lamp   = admin_next;
        result.entry_count  = length_next;
        result.entry_digits = entry_next;
        result.save_valid   = save;
        result.save_select  = save_sel;
        result.save_value   = save_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg      <= '0;
            length_reg     <= '0;
            user_reg       <= USER_CODE_RESET;
            admin_code_reg <= ADMIN_CODE_RESET;
            admin_reg      <= 1'b0;
            success_reg    <= 1'b0;
            fail_reg       <= 1'b0;
            countdown_reg  <= '0;
        end else if (advance) begin
            entry_reg      <= entry_next;
            length_reg     <= length_next;
            user_reg       <= user_next;
            admin_code_reg <= admin_code_next;
            admin_reg      <= admin_next;
            success_reg    <= success_next;
            fail_reg       <= fail_next;
            countdown_reg  <= countdown_next;
        end
    end

    // A lamp is lit exactly while the auto-clear countdown is armed.
    a_lamp_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        (success_reg || fail_reg) == (countdown_reg != '0))
        else $error("lamp state disagrees with countdown");

    a_one_lamp: assert property (@(posedge aclk) disable iff (!aresetn)
        !(success_reg && fail_reg))
        else $error("both lamps lit");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        length_reg <= FULL_COUNT)
        else $error("entry length beyond code size");

    // A save request only comes with a success indication.
    a_save_success: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && save) |=> success_reg)
        else $error("save without success");

endmodule

// ===== src/kcl_out_stage.sv =====
module kcl_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_vld,
    input  kcl_pkg::kcl_out_t result,
    output logic              advance,
    output logic              m_valid,
    input  logic              m_ready,
    output kcl_pkg::kcl_out_t m_data
);
    import kcl_pkg::*;

    logic     vld_reg;
    kcl_out_t data_reg;

    // A word moves into the result register when it is empty or being drained.
    assign advance = in_vld && (!vld_reg || m_ready);
    assign m_valid = vld_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (advance) begin
            vld_reg <= 1'b1;
        end else if (m_ready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= result;
        end
    end

endmodule

// ===== src/keypad_code_lock_controller_core.sv =====
// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  kcl_in_t: opcode, key, code_select, code_value
// m_        out        m_valid / m_ready  kcl_out_t: lamps, entry, save request
// cfg_      in         cfg_wr_en          cfg_wr_data: auto-clear tick count
//
// One word is accepted per cycle while s_ready is high; m_ presents its registered result.
// The state update and result are formed in one pass of logic between the input
// register and the result register, so back-to-back words run at full rate.
// Reset (aresetn, synchronous, active low) restores codes 0x1234 / 0x0000 and 10000 ticks.
// When m_valid is high and m_ready low the result register holds, and one more word may
// wait in the input register before s_ready drops.
module keypad_code_lock_controller_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  kcl_pkg::kcl_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output kcl_pkg::kcl_out_t           m_data,
    input  logic                        cfg_wr_en,
    input  logic [kcl_pkg::TICKS_W-1:0] cfg_wr_data
);
    import kcl_pkg::*;

    logic               in_vld;
    kcl_in_t            in_data;
    logic               advance;
    kcl_out_t           result;
    logic [TICKS_W-1:0] ticks_reg;

    // The auto-clear register. A zero value is treated as one when the
    // countdown is armed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= AUTO_CLEAR_RESET;
        end else if (cfg_wr_en) begin
            ticks_reg <= cfg_wr_data;
        end
    end

    // Input register: holds the word that is being worked on.
    kcl_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .advance (advance),
        .in_vld  (in_vld),
        .in_data (in_data)
    );

    // Lock state and the logic that applies one word to it. The state only
    // moves when the result word is taken into the result register.
    kcl_state u_state (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .in_data          (in_data),
        .auto_clear_ticks (ticks_reg),
        .result           (result)
    );

    // Result register toward the output channel.
    kcl_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_vld  (in_vld),
        .result  (result),
        .advance (advance),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // The input side only stalls while a word is parked in the input register.
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_vld)
        else $error("input stalled with empty input register");

    // A stalled output means no word advances into it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !advance)
        else $error("result register overwritten while stalled");

    // An accepted word always reaches the result register on the next edge
    // when the output side is not stalled.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (in_vld && ((m_valid && !m_ready) || advance)))
        else $error("accepted word did not progress");

endmodule

// ===== tb/sv/tb_keypad_code_lock_controller_core.sv =====
module tb_keypad_code_lock_controller_core;

    import kcl_pkg::*;

    // A stalled channel never idles for long, so a quiet spell past WATCHDOG_LIMIT without
    // any handshake while work is outstanding means the block has hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // The result of a word passes the input and result registers; settle a bit longer.
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASES         = 24;
    localparam int PHASE_WORDS    = 62;

    logic     aclk;
    logic     aresetn     = 1'b0;
    logic     s_valid     = 1'b0;
    logic     s_ready;
    kcl_in_t  s_data      = '0;
    logic     m_valid;
    logic     m_ready     = 1'b0;
    kcl_out_t m_data;
    logic     cfg_wr_en   = 1'b0;
    logic [TICKS_W-1:0] cfg_wr_data = '0;

    keypad_code_lock_controller_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Words waiting to be sent, and lock results still owed by the block.
    kcl_in_t  pending_words[$];
    kcl_out_t owed_results[$];

    int   send_gap_pct   = 22;
    int   recv_stall_pct = 58;
    logic word_taken     = 1'b0;
    int   quiet_cycles   = 0;
    int   errors         = 0;

    // Shadow of the lock state, starting from the reset values of the block.
    logic [CODE_W-1:0]  entry_bcd   = '0;
    logic [COUNT_W-1:0] entry_len   = '0;
    logic [CODE_W-1:0]  lock_user   = USER_CODE_RESET;
    logic [CODE_W-1:0]  lock_admin  = ADMIN_CODE_RESET;
    logic               admin_on    = 1'b0;
    logic               ok_lamp     = 1'b0;
    logic               bad_lamp    = 1'b0;
    logic [TICKS_W-1:0] lamp_timer  = '0;
    logic [TICKS_W-1:0] clear_ticks = AUTO_CLEAR_RESET;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Any nibble above nine reads as nine.
    function automatic logic [CODE_W-1:0] bcd_saturate(input logic [CODE_W-1:0] v);
        logic [CODE_W-1:0] r;
        r = v;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            if (r[4*i +: 4] > KEY_DIGIT_MAX) begin
                r[4*i +: 4] = KEY_DIGIT_MAX;
            end
        end
        return r;
    endfunction

    function automatic void empty_entry();
        entry_bcd = '0;
        entry_len = '0;
    endfunction

    // A verdict lights one lamp and arms the auto-clear countdown. A zero
    // setting behaves like a single tick.
    function automatic void show_verdict(input logic good);
        ok_lamp    = good;
        bad_lamp   = ~good;
        lamp_timer = (clear_ticks == '0) ? TICKS_W'(1) : clear_ticks;
    endfunction

    // Applies one word to the shadow state and returns the result word that
    // the block must produce for it.
    function automatic kcl_out_t lock_step(input kcl_in_t w);
        kcl_out_t r;
        int       slot;
        r = '0;
        case (w.opcode)
            OP_TICK: begin
                if (lamp_timer != '0) begin
                    lamp_timer = lamp_timer - 1'b1;
                    if (lamp_timer == '0) begin
                        ok_lamp  = 1'b0;
                        bad_lamp = 1'b0;
                    end
                end
            end
            OP_LOAD: begin
                if (w.code_select == SEL_ADMIN) begin
                    lock_admin = bcd_saturate(w.code_value);
                end else begin
                    lock_user = bcd_saturate(w.code_value);
                end
            end
            OP_KEY: begin
                // Every key turns both lamps off before it acts.
                ok_lamp    = 1'b0;
                bad_lamp   = 1'b0;
                lamp_timer = '0;
                if (w.key <= KEY_DIGIT_MAX) begin
                    if (entry_len < FULL_COUNT) begin
                        slot = CODE_DIGITS - 1 - int'(entry_len);
                        entry_bcd[4*slot +: 4] = w.key;
                        entry_len = entry_len + 1'b1;
                    end
                end else begin
                    case (w.key)
                        KEY_DELETE: begin
                            if (entry_len != '0) begin
                                entry_len = entry_len - 1'b1;
                                slot = CODE_DIGITS - 1 - int'(entry_len);
                                entry_bcd[4*slot +: 4] = 4'd0;
                            end
                        end
                        KEY_CLEAR: begin
                            empty_entry();
                        end
                        KEY_ENTER: begin
                            if (!admin_on) begin
                                show_verdict(entry_len == FULL_COUNT && entry_bcd == lock_user);
                                empty_entry();
                            end else if (entry_len != FULL_COUNT) begin
                                show_verdict(1'b0);
                            end else begin
                                lock_user     = entry_bcd;
                                r.save_valid  = 1'b1;
                                r.save_select = SEL_USER;
                                r.save_value  = entry_bcd;
                                show_verdict(1'b1);
                                empty_entry();
                            end
                        end
                        KEY_ADMIN: begin
                            if (admin_on) begin
                                admin_on = 1'b0;
                            end else begin
                                if (entry_len == FULL_COUNT && entry_bcd == lock_admin) begin
                                    admin_on = 1'b1;
                                end else begin
                                    show_verdict(1'b0);
                                end
                                empty_entry();
                            end
                        end
                        KEY_STAR: begin
                            if (admin_on) begin
                                if (entry_len != FULL_COUNT) begin
                                    show_verdict(1'b0);
                                end else begin
                                    lock_admin    = entry_bcd;
                                    r.save_valid  = 1'b1;
                                    r.save_select = SEL_ADMIN;
                                    r.save_value  = entry_bcd;
                                    show_verdict(1'b1);
                                    empty_entry();
                                end
                            end
                        end
                        default: begin
                            // The unused key only clears the lamps and the countdown.
                        end
                    endcase
                end
            end
            default: begin
                // Opcode three leaves the state alone.
            end
        endcase
        r.success_lamp = ok_lamp;
        r.fail_lamp    = bad_lamp;
        r.admin_lamp   = admin_on;
        r.entry_count  = entry_len;
        r.entry_digits = entry_bcd;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CODE_W-1:0] want,
                               input logic [CODE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    // Fields that a word's opcode ignores carry random bits, so that every
    // input bit toggles.
    task automatic push_key(input logic [3:0] k);
        kcl_in_t w;
        w.opcode      = OP_KEY;
        w.key         = k;
        w.code_select = 1'($urandom);
        w.code_value  = CODE_W'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic push_tick();
        kcl_in_t w;
        w.opcode      = OP_TICK;
        w.key         = 4'($urandom);
        w.code_select = 1'($urandom);
        w.code_value  = CODE_W'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic push_load(input logic sel, input logic [CODE_W-1:0] v);
        kcl_in_t w;
        w.opcode      = OP_LOAD;
        w.key         = 4'($urandom);
        w.code_select = sel;
        w.code_value  = v;
        pending_words.push_back(w);
    endtask

    // Types the first n digits of a code, most significant digit first.
    task automatic push_digits(input logic [CODE_W-1:0] code, input int n);
        for (int i = 0; i < n; i++) begin
            push_key(code[4*(CODE_DIGITS-1-i) +: 4]);
        end
    endtask

    function automatic logic [CODE_W-1:0] random_bcd();
        logic [CODE_W-1:0] c;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            c[4*i +: 4] = 4'($urandom_range(9));
        end
        return c;
    endfunction

    // Builds one phase of mostly well-formed key sequences. Guesses come from
    // the codes known at the start of the phase plus the codes this phase
    // loads or stores, so unlocks and admin logins succeed often.
    task automatic plan_phase(input int target);
        logic [CODE_W-1:0] user_guesses[$];
        logic [CODE_W-1:0] admin_guesses[$];
        logic [CODE_W-1:0] c;
        logic [31:0]       raw;
        kcl_in_t           w;
        int                start;
        int                pick;
        int                n;
        start = pending_words.size();
        user_guesses.push_back(lock_user);
        admin_guesses.push_back(lock_admin);
        while (pending_words.size() - start < target) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                // Unlock attempt, sometimes with a typo fixed by delete.
                c = ($urandom_range(5) == 0) ? random_bcd()
                    : user_guesses[$urandom_range(user_guesses.size() - 1)];
                n = ($urandom_range(7) == 0) ? $urandom_range(CODE_DIGITS) : CODE_DIGITS;
                if ($urandom_range(3) == 0) begin
                    push_key(KEY_CLEAR);
                end
                if ($urandom_range(4) == 0) begin
                    push_key(4'($urandom_range(9)));
                    push_key(KEY_DELETE);
                end
                push_digits(c, n);
                push_key(KEY_ENTER);
            end else if (pick < 52) begin
                // Admin session: log in, change one or two codes, usually log out.
                c = ($urandom_range(5) == 0) ? random_bcd()
                    : admin_guesses[$urandom_range(admin_guesses.size() - 1)];
                push_key(KEY_CLEAR);
                push_digits(c, CODE_DIGITS);
                push_key(KEY_ADMIN);
                repeat ($urandom_range(1, 2)) begin
                    c = random_bcd();
                    n = ($urandom_range(4) == 0) ? $urandom_range(CODE_DIGITS - 1)
                        : CODE_DIGITS;
                    push_digits(c, n);
                    if ($urandom_range(1) == 0) begin
                        push_key(KEY_ENTER);
                        user_guesses.push_back(c);
                    end else begin
                        push_key(KEY_STAR);
                        admin_guesses.push_back(c);
                    end
                end
                if ($urandom_range(5) != 0) begin
                    push_key(KEY_ADMIN);
                end
            end else if (pick < 62) begin
                c = CODE_W'($urandom);
                if ($urandom_range(1) == 0) begin
                    push_load(SEL_USER, c);
                    user_guesses.push_back(bcd_saturate(c));
                end else begin
                    push_load(SEL_ADMIN, c);
                    admin_guesses.push_back(bcd_saturate(c));
                end
            end else if (pick < 84) begin
                repeat ($urandom_range(1, 12)) push_tick();
            end else begin
                raw = $urandom;
                w   = raw[$bits(kcl_in_t)-1:0];
                pending_words.push_back(w);
            end
        end
    endtask

    // Waits until every word is sent and the block has delivered every owed result,
    // then lets its pipeline drain.
    task automatic wait_idle();
        while (pending_words.size() != 0 || s_valid || owed_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Sender. A new word goes out only once the previous one was taken, so
    // valid and the payload hold steady while the block stalls.
    always @(negedge aclk) begin
        if (!s_valid || word_taken) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                s_data  <= pending_words.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver, stalling at random.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Checker and hang watchdog. Results are compared before the word taken at
    // the same edge is predicted; a word can never come back in its own cycle.
    always @(posedge aclk) begin
        kcl_out_t want;
        word_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result word %h arrived with nothing expected", m_data);
                    errors++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("success_lamp", CODE_W'(want.success_lamp),
                                CODE_W'(m_data.success_lamp));
                    check_field("fail_lamp", CODE_W'(want.fail_lamp),
                                CODE_W'(m_data.fail_lamp));
                    check_field("admin_lamp", CODE_W'(want.admin_lamp),
                                CODE_W'(m_data.admin_lamp));
                    check_field("entry_count", CODE_W'(want.entry_count),
                                CODE_W'(m_data.entry_count));
                    check_field("entry_digits", want.entry_digits, m_data.entry_digits);
                    check_field("save_valid", CODE_W'(want.save_valid),
                                CODE_W'(m_data.save_valid));
                    check_field("save_select", CODE_W'(want.save_select),
                                CODE_W'(m_data.save_select));
                    check_field("save_value", want.save_value, m_data.save_value);
                end
            end
            if (s_valid && s_ready) begin
                owed_results.push_back(lock_step(s_data));
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (pending_words.size() == 0 && !s_valid && owed_results.size() == 0)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        logic [TICKS_W-1:0] tick_settings[8];
        // Short countdowns let lamps expire inside a phase; zero, one and the
        // largest value cover the extremes of the register.
        tick_settings = '{16'd3, 16'd1, 16'd0, 16'hFFFF, 16'd2, 16'd7, 16'd12, 16'd5};

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed opening with reset codes 1234 (user) and 0000 (admin).
        pending_words.push_back('1);        // opcode three, every bit set
        push_tick();                        // tick while the countdown is off
        push_key(4'd11);                    // unused key
        push_key(KEY_ENTER);                // empty entry fails and arms the countdown
        push_tick();                        // countdown runs
        push_key(KEY_DELETE);               // delete on an empty entry
        push_key(KEY_STAR);                 // star outside admin mode
        push_key(KEY_ADMIN);                // admin login with no entry fails
        push_digits(16'h1234, CODE_DIGITS);
        push_key(KEY_ENTER);                // correct user code
        push_digits(16'h0000, CODE_DIGITS);
        push_key(4'd9);                     // entry already full, digit dropped
        push_key(KEY_ADMIN);                // admin login
        push_key(KEY_ENTER);                // incomplete entry in admin mode
        push_key(KEY_STAR);
        push_digits(16'h5678, CODE_DIGITS);
        push_key(KEY_ENTER);                // new user code saved
        push_key(KEY_ADMIN);                // leave admin mode
        push_load(SEL_USER, 16'hFFFF);      // every digit clamps to nine
        push_load(SEL_ADMIN, 16'hA0C9);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= tick_settings[phase % 8];
            clear_ticks  = tick_settings[phase % 8];
            @(negedge aclk);
            cfg_wr_en <= 1'b0;
            // Receiver-heavy stalls, then sender-heavy, then full rate.
            if (phase < PHASES / 3) begin
                send_gap_pct   = 22;
                recv_stall_pct = 58;
            end else if (phase < 2 * PHASES / 3) begin
                send_gap_pct   = 58;
                recv_stall_pct = 22;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            plan_phase(PHASE_WORDS);
        end

        wait_idle();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
